// ===== rtl/core/cwdra_pkg.sv =====
// Shared types, codes and constants for the dawn-ramp alarm clock.
// No dependencies; every other file in rtl/core refers to this package.
package cwdra_pkg;

    // Ramp length in steps and calendar limits
    localparam int RAMP_STEPS = 255;
    localparam int SEC_LIMIT  = 60;
    localparam int MIN_LIMIT  = 60;
    localparam int HOUR_LIMIT = 24;
    localparam int DAY_LIMIT  = 8;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_LOAD   = 2'd2
    } t_kind;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALARM_HOUR   = 3'd0,
        CFG_ALARM_MINUTE = 3'd1,
        CFG_RAMP_MINUTES = 3'd2,
        CFG_WEEKDAY_MASK = 3'd3,
        CFG_ALARM_ENABLE = 3'd4
    } t_cfg_index;

    // Configuration registers as one group
    typedef struct packed {
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic [4:0] ramp_minutes;
        logic [6:0] weekday_mask;
        logic       alarm_enable;
    } t_cfg;

    // Time of day and weekday
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } t_time;

    // A request held in the input register
    typedef struct packed {
        logic [1:0] kind;
        t_time      load;
    } t_req;

    // Seconds per ramp step for every dawn period code:
    // (period * 60 + RAMP_STEPS/2) / RAMP_STEPS, kept to 8 bits
    typedef logic [31:0][7:0] t_step_table;

    function automatic t_step_table build_step_table();
        t_step_table tbl;
        int          i;
        for (i = 0; i < 32; i++) begin
            tbl[i] = 8'((i * 60 + RAMP_STEPS / 2) / RAMP_STEPS);
        end
        return tbl;
    endfunction

    localparam t_step_table STEP_TABLE = build_step_table();

endpackage

// ===== rtl/core/cwdra_time.sv =====
// Timekeeping: second, minute, hour and weekday counters plus the alarm match.
// Depends on cwdra_pkg.
module cwdra_time (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [1:0]           i_kind,
    input  cwdra_pkg::t_time     i_load,
    input  cwdra_pkg::t_cfg      i_cfg,
    output cwdra_pkg::t_time     o_time_next,
    output logic                 o_alarm_hit
);

    cwdra_pkg::t_time r_time;
    cwdra_pkg::t_time n_time;

    logic [6:0] w_sec_inc;
    logic [6:0] w_min_inc;
    logic [5:0] w_hour_inc;
    logic [3:0] w_day_inc;
    logic       w_sec_wrap;
    logic       w_min_wrap;
    logic       w_hour_wrap;
    logic       w_day_wrap;

    logic [4:0] w_start_hour;
    logic [5:0] w_start_min;
    logic [6:0] w_borrow_min;
    logic [7:0] w_mask_ext;
    logic       w_day_on;
    logic       w_match;

    // Increments, one bit wider so that a loaded out-of-range count still rolls over
    assign w_sec_inc   = {1'b0, r_time.second} + 7'd1;
    assign w_min_inc   = {1'b0, r_time.minute} + 7'd1;
    assign w_hour_inc  = {1'b0, r_time.hour} + 6'd1;
    assign w_day_inc   = {1'b0, r_time.weekday} + 4'd1;
    assign w_sec_wrap  = (w_sec_inc >= 7'(cwdra_pkg::SEC_LIMIT));
    assign w_min_wrap  = (w_min_inc >= 7'(cwdra_pkg::MIN_LIMIT));
    assign w_hour_wrap = (w_hour_inc >= 6'(cwdra_pkg::HOUR_LIMIT));
    assign w_day_wrap  = (w_day_inc >= 4'(cwdra_pkg::DAY_LIMIT));

    // Ramp start time: alarm time less the dawn period, borrowing from the hour
    assign w_borrow_min = 7'd60 - {2'b00, i_cfg.ramp_minutes} + {1'b0, i_cfg.alarm_minute};

    always_comb begin
        if (i_cfg.alarm_minute >= {1'b0, i_cfg.ramp_minutes}) begin
            w_start_hour = i_cfg.alarm_hour;
            w_start_min  = i_cfg.alarm_minute - {1'b0, i_cfg.ramp_minutes};
        end else begin
            w_start_hour = (i_cfg.alarm_hour == 5'd0) ? 5'd23 : (i_cfg.alarm_hour - 5'd1);
            w_start_min  = w_borrow_min[5:0];
        end
    end

    // Weekday zero has no mask bit
    assign w_mask_ext = {i_cfg.weekday_mask, 1'b0};
    assign w_day_on   = w_mask_ext[n_time.weekday];
    assign w_match    = i_cfg.alarm_enable && w_day_on &&
                        (w_start_hour == n_time.hour) && (w_start_min == n_time.minute);

    // Alarm is only checked on a tick that rolls the minute over
    assign o_alarm_hit = (i_kind == cwdra_pkg::KIND_TICK) && w_sec_wrap && w_match;

    // Next time of day
    always_comb begin
        n_time = r_time;
        case (i_kind)
            cwdra_pkg::KIND_TICK: begin
                if (!w_sec_wrap) begin
                    n_time.second = w_sec_inc[5:0];
                end else begin
                    n_time.second = 6'd0;
                    if (!w_min_wrap) begin
                        n_time.minute = w_min_inc[5:0];
                    end else begin
                        n_time.minute = 6'd0;
                        if (!w_hour_wrap) begin
                            n_time.hour = w_hour_inc[4:0];
                        end else begin
                            n_time.hour    = 5'd0;
                            n_time.weekday = w_day_wrap ? 3'd1 : w_day_inc[2:0];
                        end
                    end
                end
            end
            cwdra_pkg::KIND_LOAD: begin
                n_time = i_load;
            end
            default: begin
                n_time = r_time;
            end
        endcase
    end

    assign o_time_next = n_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.hour    <= 5'd0;
            r_time.minute  <= 6'd0;
            r_time.second  <= 6'd0;
            r_time.weekday <= 3'd1;
        end else if (i_advance) begin
            r_time <= n_time;
        end
    end

endmodule

// ===== rtl/core/cwdra_ramp.sv =====
// Dawn light ramp: ramp count and seconds-within-step counter.
// Depends on cwdra_pkg; takes the alarm match from cwdra_time.
module cwdra_ramp (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [1:0] i_kind,
    input  logic       i_alarm_hit,
    input  logic [7:0] i_step_len,
    output logic [7:0] o_ramp_next
);

    logic [7:0] r_ramp;
    logic [7:0] r_step_sec;
    logic [7:0] n_ramp;
    logic [7:0] n_step_sec;
    logic [7:0] w_step_inc;

    assign w_step_inc = r_step_sec + 8'd1;

    // Step the ramp on a tick, then let an alarm start override it
    always_comb begin
        n_ramp     = r_ramp;
        n_step_sec = r_step_sec;
        case (i_kind)
            cwdra_pkg::KIND_TICK: begin
                if (r_ramp != 8'd0) begin
                    if (w_step_inc == i_step_len) begin
                        n_step_sec = 8'd0;
                        n_ramp     = r_ramp - 8'd1;
                    end else begin
                        n_step_sec = w_step_inc;
                    end
                end
                if (i_alarm_hit) begin
                    n_ramp     = 8'(cwdra_pkg::RAMP_STEPS);
                    n_step_sec = 8'd0;
                end
            end
            cwdra_pkg::KIND_CANCEL: begin
                n_ramp     = 8'd0;
                n_step_sec = 8'd0;
            end
            default: begin
                n_ramp     = r_ramp;
                n_step_sec = r_step_sec;
            end
        endcase
    end

    assign o_ramp_next = n_ramp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp     <= 8'd0;
            r_step_sec <= 8'd0;
        end else if (i_advance) begin
            r_ramp     <= n_ramp;
            r_step_sec <= n_step_sec;
        end
    end

endmodule

// ===== rtl/core/clock_with_dawn_ramp_alarm_top.sv =====
// Top level of the dawn-ramp alarm clock: request register, configuration
// registers, result register. Depends on cwdra_pkg, cwdra_time and cwdra_ramp.

// Each request (tick, cancel or load) is taken into an input register, its
// state update is computed combinationally, and its result is written into
// the output register when the result register is free. One request per
// cycle is sustained while the result channel does not stall. A stalled
// result holds both registers, after which the input side stalls too. The
// step table for the dawn period is a 32-entry constant lookup. Configuration
// writes take effect on the next edge and should only be issued while idle.
module clock_with_dawn_ramp_alarm_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration port
    input  logic                              i_cfg_we,
    input  logic [cwdra_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cwdra_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_kind,
    input  logic [4:0]                        i_new_hour,
    input  logic [5:0]                        i_new_minute,
    input  logic [5:0]                        i_new_second,
    input  logic [2:0]                        i_new_weekday,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [4:0]                        o_hour,
    output logic [5:0]                        o_minute,
    output logic [5:0]                        o_second,
    output logic [2:0]                        o_weekday,
    output logic                              o_light_on,
    output logic [7:0]                        o_ramp_level,
    output logic                              o_alarm_started
);

    cwdra_pkg::t_cfg  r_cfg;
    cwdra_pkg::t_req  r_req;
    logic             r_req_valid;
    logic             r_out_valid;
    cwdra_pkg::t_time r_out_time;
    logic [7:0]       r_out_ramp;
    logic             r_out_started;

    logic             w_advance;
    cwdra_pkg::t_time w_time_next;
    logic             w_alarm_hit;
    logic [7:0]       w_ramp_next;
    logic [7:0]       w_step_len;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_hour   <= 5'd7;
            r_cfg.alarm_minute <= 6'd0;
            r_cfg.ramp_minutes <= 5'd15;
            r_cfg.weekday_mask <= 7'd0;
            r_cfg.alarm_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cwdra_pkg::CFG_ALARM_HOUR:   r_cfg.alarm_hour   <= i_cfg_data[4:0];
                cwdra_pkg::CFG_ALARM_MINUTE: r_cfg.alarm_minute <= i_cfg_data[5:0];
                cwdra_pkg::CFG_RAMP_MINUTES: r_cfg.ramp_minutes <= i_cfg_data[4:0];
                cwdra_pkg::CFG_WEEKDAY_MASK: r_cfg.weekday_mask <= i_cfg_data[6:0];
                cwdra_pkg::CFG_ALARM_ENABLE: r_cfg.alarm_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_step_len = cwdra_pkg::STEP_TABLE[r_cfg.ramp_minutes];

    // Handshake: the held request moves on when the result register is free
    assign w_advance  = r_req_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_req_valid && !w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_req_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_req.kind         <= i_kind;
            r_req.load.hour    <= i_new_hour;
            r_req.load.minute  <= i_new_minute;
            r_req.load.second  <= i_new_second;
            r_req.load.weekday <= i_new_weekday;
        end
    end

    cwdra_time u_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_kind      (r_req.kind),
        .i_load      (r_req.load),
        .i_cfg       (r_cfg),
        .o_time_next (w_time_next),
        .o_alarm_hit (w_alarm_hit)
    );

    cwdra_ramp u_ramp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_kind      (r_req.kind),
        .i_alarm_hit (w_alarm_hit),
        .i_step_len  (w_step_len),
        .o_ramp_next (w_ramp_next)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_time    <= w_time_next;
            r_out_ramp    <= w_ramp_next;
            r_out_started <= w_alarm_hit;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hour          = r_out_time.hour;
    assign o_minute        = r_out_time.minute;
    assign o_second        = r_out_time.second;
    assign o_weekday       = r_out_time.weekday;
    assign o_light_on      = (r_out_ramp != 8'd0);
    assign o_ramp_level    = ~r_out_ramp;
    assign o_alarm_started = r_out_started;

endmodule
